FILE: rtl/rfc_pkg.sv
// ----------------------------------------------------------------------------
// rfc_pkg: shared types and constants of the RTCM 3 frame checker
// Phase and verdict codes, issue levels, register indexes and the
// byte-wide CRC-24Q update.
// ----------------------------------------------------------------------------
`default_nettype none

package rfc_pkg;

	localparam logic [7:0]  PREAMBLE   = 8'hD3;
	localparam logic [1:0]  LEN_HI_MASK = 2'h3;
	localparam logic [23:0] CRC24Q_POLY = 24'h864CFB; // 0x1864CFB without the x^24 term
	localparam int unsigned LEN_W      = 10;
	localparam int unsigned THR_W      = 10;
	localparam logic [LEN_W-1:0] CRC_BYTES = 10'd3;

	typedef enum logic [2:0] {
		PH_HUNT    = 3'd0,
		PH_HDR1    = 3'd1,
		PH_HDR2    = 3'd2,
		PH_PAYLOAD = 3'd3,
		PH_CRC     = 3'd4
	} phase_t;

	typedef enum logic [2:0] {
		VERDICT_NONE    = 3'd0,
		VERDICT_GOOD    = 3'd1,
		VERDICT_EMPTY   = 3'd2,
		VERDICT_ZERO    = 3'd3,
		VERDICT_CRC_BAD = 3'd4
	} verdict_t;

	typedef enum logic [2:0] {
		LEVEL_NONE     = 3'd0,
		LEVEL_WARN     = 3'd1,
		LEVEL_ESCALATE = 3'd2,
		LEVEL_ERROR    = 3'd3,
		LEVEL_FATAL    = 3'd4
	} level_t;

	localparam logic REG_WARN_THRESHOLD  = 1'b0;
	localparam logic REG_FATAL_THRESHOLD = 1'b1;

	// Per-item framing marks handed from the framer to the health tracker
	typedef struct packed {
		logic             in_frame;
		logic             start;
		logic             last;
		verdict_t         verdict;
		logic [LEN_W-1:0] length;
	} frame_info_t;

	// MSB-first CRC-24Q over one byte, no reflection
	function automatic logic [23:0] crc24q_byte(input logic [23:0] crc, input logic [7:0] b);
		logic [23:0] c;
		logic        top;
		c = crc ^ {b, 16'h0000};
		for (int k = 0; k < 8; k++) begin
			top = c[23];
			c = {c[22:0], 1'b0};
			if (top) begin
				c = c ^ CRC24Q_POLY;
			end
		end
		return c;
	endfunction

endpackage

`default_nettype wire

FILE: rtl/rtcm3_frame_checker_unit.sv
// ----------------------------------------------------------------------------
// rtcm3_frame_checker_unit: RTCM 3 framing and CRC-24Q check on a byte stream
// Hunts for the preamble, parses the length, checks CRC-24Q and tracks health.
// ----------------------------------------------------------------------------
// The item of a byte is held in the input register, then moves to the output
// register, where it waits until it is taken.
// Throughput: one byte per cycle; the CRC-24Q update is byte-wide.
// The input register and output register both stay full under back-pressure,
// so a new byte is taken in every cycle that the output side drains.
// Reset (arst_n low, asynchronous): framer hunts, count and fatal clear,
// thresholds return to 3 and 10, both stream stages empty.
`default_nettype none

module rtcm3_frame_checker_unit #(
	parameter int unsigned COUNT_MAX = 1023
) (
	input  wire         clk,
	input  wire         arst_n,
	// Byte stream in
	input  wire         s_axis_tvalid,
	output logic        s_axis_tready,
	input  wire  [7:0]  s_axis_tdata,   // [7:0] data_byte
	// Checked stream out
	output logic        m_axis_tvalid,
	input  wire         m_axis_tready,
	output logic [39:0] m_axis_tdata,   // [7:0] out_byte, [10:8] verdict,
	                                    // [20:11] frame length, [23:21] issue_level,
	                                    // [33:24] bad_count, [34] fatal, [39:35] zero
	output logic [1:0]  m_axis_tuser,   // [0] in_frame, [1] frame_start
	output logic        m_axis_tlast,   // frame_end
	// Configuration writes
	input  wire         cfg_we,
	input  wire         cfg_index,
	input  wire  [9:0]  cfg_data
);

	logic                 valid_s1;
	logic [7:0]           data_s1;
	logic                 advance;
	rfc_pkg::frame_info_t info;
	rfc_pkg::level_t      level;
	logic [9:0]           bad_count;
	logic                 fatal;

	logic                 out_valid_q;
	logic [39:0]          out_data_q;
	logic [1:0]           out_user_q;
	logic                 out_last_q;

	// Move the held byte to the output register when that register is free
	// or is being emptied this cycle; the framer state moves with it.
	assign advance       = valid_s1 && (!out_valid_q || m_axis_tready);
	assign s_axis_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	// Payload register: load on accept only
	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			data_s1 <= s_axis_tdata;
		end
	end

	rfc_framer u_framer (
		.clk       (clk),
		.arst_n    (arst_n),
		.advance   (advance),
		.data_byte (data_s1),
		.info      (info)
	);

	rfc_health #(
		.COUNT_MAX (COUNT_MAX)
	) u_health (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.advance   (advance),
		.info      (info),
		.level     (level),
		.bad_count (bad_count),
		.fatal     (fatal)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Hold the result until taken
	always_ff @(posedge clk) begin
		if (advance) begin
			out_data_q <= {5'b00000, fatal, bad_count, level, info.length,
				info.verdict, data_s1};
			out_user_q <= {info.start, info.in_frame};
			out_last_q <= info.last;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;
	assign m_axis_tuser  = out_user_q;
	assign m_axis_tlast  = out_last_q;

`ifndef ASSERT_OFF
	a_last_verdict: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tlast |-> m_axis_tdata[10:8] != rfc_pkg::VERDICT_NONE)
		else $error("frame end item without verdict");
	a_level_only_on_end: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tdata[23:21] != rfc_pkg::LEVEL_NONE |-> m_axis_tlast)
		else $error("issue level outside frame end");
	a_bad_counts: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tlast && m_axis_tdata[10:8] != rfc_pkg::VERDICT_GOOD
		|-> m_axis_tdata[23:21] != rfc_pkg::LEVEL_NONE)
		else $error("bad frame without issue level");
	a_start_in_frame: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser[1] |-> m_axis_tuser[0])
		else $error("frame start outside frame");
`endif

endmodule

`default_nettype wire

FILE: rtl/rfc_framer.sv
// ----------------------------------------------------------------------------
// rfc_framer: preamble hunt, header parse, payload and CRC tracking
// Advances one byte per enable and reports the framing marks of that byte.
// ----------------------------------------------------------------------------
`default_nettype none

module rfc_framer (
	input  wire                       clk,
	input  wire                       arst_n,
	input  wire                       advance,
	input  wire  [7:0]                data_byte,
	output rfc_pkg::frame_info_t      info
);

	rfc_pkg::phase_t             phase_q, phase_d;
	logic [rfc_pkg::LEN_W-1:0]   len_q, len_d;
	logic [rfc_pkg::LEN_W-1:0]   pos_q, pos_d;
	logic [23:0]                 crc_q, crc_d;
	logic [23:0]                 rx_q, rx_d;
	logic                        zero_q, zero_d;
	logic [23:0]                 crc_upd;

	assign crc_upd = rfc_pkg::crc24q_byte(crc_q, data_byte);

	// Next state
	always_comb begin
		phase_d = phase_q;
		len_d   = len_q;
		pos_d   = pos_q;
		crc_d   = crc_q;
		rx_d    = rx_q;
		zero_d  = zero_q;
		unique case (phase_q)
			rfc_pkg::PH_HDR1: begin
				len_d   = {data_byte[1:0] & rfc_pkg::LEN_HI_MASK, 8'h00};
				crc_d   = crc_upd;
				phase_d = rfc_pkg::PH_HDR2;
			end
			rfc_pkg::PH_HDR2: begin
				len_d   = {len_q[9:8], data_byte};
				crc_d   = crc_upd;
				pos_d   = '0;
				phase_d = (len_d == '0) ? rfc_pkg::PH_CRC : rfc_pkg::PH_PAYLOAD;
			end
			rfc_pkg::PH_PAYLOAD: begin
				crc_d = crc_upd;
				if (data_byte != 8'h00) begin
					zero_d = 1'b0;
				end
				pos_d = pos_q + 1'b1;
				if (pos_d >= len_q) begin
					pos_d   = '0;
					phase_d = rfc_pkg::PH_CRC;
				end
			end
			rfc_pkg::PH_CRC: begin
				rx_d  = {rx_q[15:0], data_byte};
				pos_d = pos_q + 1'b1;
				if (pos_d >= rfc_pkg::CRC_BYTES) begin
					pos_d   = '0;
					phase_d = rfc_pkg::PH_HUNT;
				end
			end
			default: begin
				if (data_byte == rfc_pkg::PREAMBLE) begin
					len_d   = '0;
					pos_d   = '0;
					rx_d    = '0;
					zero_d  = 1'b1;
					crc_d   = rfc_pkg::crc24q_byte(24'h000000, data_byte);
					phase_d = rfc_pkg::PH_HDR1;
				end else begin
					phase_d = rfc_pkg::PH_HUNT;
				end
			end
		endcase
	end

	// Outputs
	always_comb begin
		info          = '0;
		info.in_frame = 1'b1;
		info.verdict  = rfc_pkg::VERDICT_NONE;
		info.length   = len_q;
		unique case (phase_q)
			rfc_pkg::PH_HDR1, rfc_pkg::PH_HDR2: begin
				info.length = len_d;
			end
			rfc_pkg::PH_PAYLOAD: begin
				info.length = len_q;
			end
			rfc_pkg::PH_CRC: begin
				if (phase_d == rfc_pkg::PH_HUNT) begin
					info.last = 1'b1;
					if (len_q == '0) begin
						info.verdict = rfc_pkg::VERDICT_EMPTY;
					end else if (zero_q) begin
						info.verdict = rfc_pkg::VERDICT_ZERO;
					end else if (rx_d != crc_q) begin
						info.verdict = rfc_pkg::VERDICT_CRC_BAD;
					end else begin
						info.verdict = rfc_pkg::VERDICT_GOOD;
					end
				end
			end
			default: begin
				info.length   = '0;
				info.start    = (data_byte == rfc_pkg::PREAMBLE);
				info.in_frame = (data_byte == rfc_pkg::PREAMBLE);
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= rfc_pkg::PH_HUNT;
			len_q   <= '0;
			pos_q   <= '0;
			crc_q   <= '0;
			rx_q    <= '0;
			zero_q  <= 1'b1;
		end else if (advance) begin
			phase_q <= phase_d;
			len_q   <= len_d;
			pos_q   <= pos_d;
			crc_q   <= crc_d;
			rx_q    <= rx_d;
			zero_q  <= zero_d;
		end
	end

`ifndef ASSERT_OFF
	a_last_has_verdict: assert property (@(posedge clk) disable iff (!arst_n)
		info.last |-> info.verdict != rfc_pkg::VERDICT_NONE)
		else $error("frame end without verdict");
	a_start_from_hunt: assert property (@(posedge clk) disable iff (!arst_n)
		advance && info.start |=> phase_q == rfc_pkg::PH_HDR1)
		else $error("preamble did not open header");
	a_crc_leads_to_hunt: assert property (@(posedge clk) disable iff (!arst_n)
		advance && info.last |=> phase_q == rfc_pkg::PH_HUNT)
		else $error("frame end did not return to hunt");
`endif

endmodule

`default_nettype wire

FILE: rtl/rfc_health.sv
// ----------------------------------------------------------------------------
// rfc_health: consecutive-failure count, escalation level, sticky fatal
// Holds the two threshold registers written through the config port.
// ----------------------------------------------------------------------------
`default_nettype none

module rfc_health #(
	parameter int unsigned COUNT_MAX = 1023
) (
	input  wire                         clk,
	input  wire                         arst_n,
	input  wire                         cfg_we,
	input  wire                         cfg_index,
	input  wire  [rfc_pkg::THR_W-1:0]   cfg_data,
	input  wire                         advance,
	input  wire rfc_pkg::frame_info_t   info,
	output rfc_pkg::level_t             level,
	output logic [9:0]                  bad_count,
	output logic                        fatal
);

	localparam int unsigned CW   = $clog2(COUNT_MAX + 1);
	localparam int unsigned CMPW = (CW > rfc_pkg::THR_W) ? CW : rfc_pkg::THR_W;
	localparam logic [CW-1:0] CNT_SAT = CW'(COUNT_MAX);

	logic [rfc_pkg::THR_W-1:0] warn_q, fatal_thr_q;
	logic [CW-1:0]             cnt_q, cnt_d;
	logic                      fatal_q, fatal_d;
	logic [CMPW-1:0]           cnt_ext, wt, ft;
	logic                      bad;

	assign bad = info.last && (info.verdict != rfc_pkg::VERDICT_GOOD);

	// A threshold of zero acts as one
	assign wt = CMPW'((warn_q == '0) ? rfc_pkg::THR_W'(1) : warn_q);
	assign ft = CMPW'((fatal_thr_q == '0) ? rfc_pkg::THR_W'(1) : fatal_thr_q);

	always_comb begin
		cnt_d   = cnt_q;
		fatal_d = fatal_q;
		level   = rfc_pkg::LEVEL_NONE;
		if (info.last && !bad) begin
			cnt_d = '0;
		end else if (bad) begin
			if (cnt_q < CNT_SAT) begin
				cnt_d = cnt_q + 1'b1;
			end
		end
		cnt_ext = CMPW'(cnt_d);
		if (bad) begin
			priority if (cnt_ext < wt) begin
				level = rfc_pkg::LEVEL_WARN;
			end else if (cnt_ext < ft) begin
				level = (cnt_ext == wt) ? rfc_pkg::LEVEL_ESCALATE : rfc_pkg::LEVEL_ERROR;
			end else begin
				level   = rfc_pkg::LEVEL_FATAL;
				fatal_d = 1'b1;
			end
		end
	end

	assign bad_count = cnt_ext[9:0];
	assign fatal     = fatal_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			warn_q      <= 10'd3;
			fatal_thr_q <= 10'd10;
		end else if (cfg_we) begin
			unique case (cfg_index)
				rfc_pkg::REG_WARN_THRESHOLD:  warn_q      <= cfg_data;
				rfc_pkg::REG_FATAL_THRESHOLD: fatal_thr_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q   <= '0;
			fatal_q <= 1'b0;
		end else if (advance) begin
			cnt_q   <= cnt_d;
			fatal_q <= fatal_d;
		end
	end

`ifndef ASSERT_OFF
	a_fatal_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		fatal_q |=> fatal_q)
		else $error("fatal flag cleared");
	a_count_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_SAT)
		else $error("failure count beyond saturation");
	a_good_clears: assert property (@(posedge clk) disable iff (!arst_n)
		advance && info.last && !bad |=> cnt_q == '0)
		else $error("good frame did not clear count");
`endif

endmodule

`default_nettype wire

FILE: tb/sv/testbench.sv
// ----------------------------------------------------------------------------
// testbench: stream-level check of the RTCM 3 frame checker unit
// Feeds byte streams of noise, well-formed frames, spoiled frames and cut-off
// frames, predicts every output item with an in-bench framer and health
// tracker, and checks each item field by field under random stalls.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps
`default_nettype none

module testbench;

	localparam int unsigned COUNT_CEIL = 1023;
	localparam int unsigned RUN_LIMIT  = 1500000;
	localparam logic [23:0] CRC_TAPS   = 24'h864CFB;

	// One output item as it travels: tdata bits from the top down, then tlast and tuser
	typedef struct packed {
		logic [4:0]        pad;
		logic              fatal_mark;
		logic [9:0]        bad_count;
		rfc_pkg::level_t   level;
		logic [9:0]        length;
		rfc_pkg::verdict_t verdict;
		logic [7:0]        byte_val;
		logic              end_mark;
		logic              start_mark;
		logic              in_frame;
	} check_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	wire         s_axis_tready;
	logic [7:0]  s_axis_tdata = 8'h00;
	wire         m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	wire  [39:0] m_axis_tdata;   // [7:0] out_byte, [10:8] verdict, [20:11] frame length,
	                             // [23:21] issue_level, [33:24] bad_count, [34] fatal,
	                             // [39:35] zero
	wire  [1:0]  m_axis_tuser;   // [0] in_frame, [1] frame_start
	wire         m_axis_tlast;
	logic        cfg_we = 1'b0;
	logic        cfg_index = 1'b0;
	logic [9:0]  cfg_data = 10'd0;

	rtcm3_frame_checker_unit dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	always #1 clk = ~clk;

	// Bytes waiting to be sent, and the checked items still owed by the block
	logic [7:0] byte_q[$];
	check_t     owed_q[$];

	int unsigned queued_total = 0;
	int unsigned sent_total = 0;
	int unsigned seen_total = 0;
	int unsigned errors = 0;
	int unsigned cycles = 0;
	int unsigned tally[5] = '{default: 0};
	bit          fatal_observed = 1'b0;
	bit          calm = 1'b0;

	// Framer and health state of the in-bench predictor
	rfc_pkg::phase_t fr_phase = rfc_pkg::PH_HUNT;
	logic [9:0]  fr_len = '0;
	logic [10:0] fr_pos = '0;
	logic [23:0] fr_crc = '0;
	logic [23:0] fr_rx = '0;
	logic        fr_zero = 1'b1;
	logic [9:0]  fail_cnt = '0;
	logic        fatal_seen = 1'b0;
	logic [9:0]  warn_thr = 10'd3;
	logic [9:0]  fatal_thr = 10'd10;

	// CRC-24Q, one input bit at a time, MSB first
	function automatic logic [23:0] crc_next(input logic [23:0] crc, input logic [7:0] b);
		logic [23:0] c;
		logic        fb;
		c = crc;
		for (int i = 7; i >= 0; i--) begin
			fb = c[23] ^ b[i];
			c = {c[22:0], 1'b0};
			if (fb) begin
				c = c ^ CRC_TAPS;
			end
		end
		return c;
	endfunction

	// Advance the framer by one byte and work out the item it yields
	task automatic track_byte(input logic [7:0] b, output check_t r);
		logic [9:0] wt;
		logic [9:0] ft;
		r = '0;
		r.byte_val = b;
		r.in_frame = 1'b1;
		r.verdict = rfc_pkg::VERDICT_NONE;
		r.level = rfc_pkg::LEVEL_NONE;
		r.length = fr_len;
		case (fr_phase)
			rfc_pkg::PH_HDR1: begin
				// only the low two bits carry length; the reserved bits are ignored
				fr_len = {b[1:0], 8'h00};
				fr_crc = crc_next(fr_crc, b);
				r.length = fr_len;
				fr_phase = rfc_pkg::PH_HDR2;
			end
			rfc_pkg::PH_HDR2: begin
				fr_len = {fr_len[9:8], b};
				fr_crc = crc_next(fr_crc, b);
				r.length = fr_len;
				fr_pos = '0;
				fr_phase = (fr_len == 10'd0) ? rfc_pkg::PH_CRC : rfc_pkg::PH_PAYLOAD;
			end
			rfc_pkg::PH_PAYLOAD: begin
				fr_crc = crc_next(fr_crc, b);
				if (b != 8'h00) begin
					fr_zero = 1'b0;
				end
				fr_pos = fr_pos + 11'd1;
				if (fr_pos >= {1'b0, fr_len}) begin
					fr_pos = '0;
					fr_phase = rfc_pkg::PH_CRC;
				end
			end
			rfc_pkg::PH_CRC: begin
				fr_rx = {fr_rx[15:0], b};
				fr_pos = fr_pos + 11'd1;
				if (fr_pos >= 11'd3) begin
					// a threshold of zero behaves as one
					wt = (warn_thr != 10'd0) ? warn_thr : 10'd1;
					ft = (fatal_thr != 10'd0) ? fatal_thr : 10'd1;
					r.end_mark = 1'b1;
					if (fr_len == 10'd0) begin
						r.verdict = rfc_pkg::VERDICT_EMPTY;
					end else if (fr_zero) begin
						r.verdict = rfc_pkg::VERDICT_ZERO;
					end else if (fr_rx != fr_crc) begin
						r.verdict = rfc_pkg::VERDICT_CRC_BAD;
					end else begin
						r.verdict = rfc_pkg::VERDICT_GOOD;
					end
					if (r.verdict == rfc_pkg::VERDICT_GOOD) begin
						fail_cnt = '0;
					end else begin
						if (fail_cnt < COUNT_CEIL) begin
							fail_cnt = fail_cnt + 10'd1;
						end
						// warning, then escalation at the warn threshold, then error, then fatal;
						// with warn above fatal, warnings run up to warn and fatal follows directly
						if (fail_cnt < wt) begin
							r.level = rfc_pkg::LEVEL_WARN;
						end else if (fail_cnt < ft) begin
							r.level = (fail_cnt == wt) ? rfc_pkg::LEVEL_ESCALATE
							                           : rfc_pkg::LEVEL_ERROR;
						end else begin
							r.level = rfc_pkg::LEVEL_FATAL;
							fatal_seen = 1'b1;
						end
					end
					fr_pos = '0;
					fr_phase = rfc_pkg::PH_HUNT;
				end
			end
			default: begin
				if (b == rfc_pkg::PREAMBLE) begin
					r.start_mark = 1'b1;
					fr_len = '0;
					fr_pos = '0;
					fr_rx = '0;
					fr_zero = 1'b1;
					fr_crc = crc_next(24'h000000, b);
					fr_phase = rfc_pkg::PH_HDR1;
				end else begin
					r.in_frame = 1'b0;
					fr_phase = rfc_pkg::PH_HUNT;
				end
				r.length = '0;
			end
		endcase
		r.bad_count = fail_cnt;
		r.fatal_mark = fatal_seen;
	endtask

	// ---------------------------------------------------------------- driver
	// Hold an item until taken; between items insert random idle bursts.
	int unsigned gap_left = 0;
	always @(posedge clk or negedge arst_n) begin
		check_t predicted;
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
			s_axis_tdata <= 8'h00;
			gap_left <= 0;
		end else begin
			if (s_axis_tvalid && s_axis_tready) begin
				track_byte(s_axis_tdata, predicted);
				owed_q = {owed_q, predicted};
				sent_total++;
			end
			if (s_axis_tvalid && !s_axis_tready) begin
				// hold the current item
			end else if (gap_left != 0) begin
				gap_left <= gap_left - 1;
				s_axis_tvalid <= 1'b0;
			end else if (!calm && $urandom_range(0, 11) == 0) begin
				gap_left <= $urandom_range(0, 18);
				s_axis_tvalid <= 1'b0;
			end else if (byte_q.size() != 0) begin
				s_axis_tdata <= byte_q.pop_front();
				s_axis_tvalid <= 1'b1;
			end else begin
				s_axis_tvalid <= 1'b0;
			end
		end
	end

	// --------------------------------------------------------------- monitor
	// Check each accepted item against the oldest owed one, then pick tready.
	int unsigned stall_left = 0;
	always @(posedge clk or negedge arst_n) begin
		check_t got;
		check_t want;
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
			stall_left <= 0;
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				got = {m_axis_tdata, m_axis_tlast, m_axis_tuser[1], m_axis_tuser[0]};
				seen_total++;
				if (got.end_mark && got.verdict <= rfc_pkg::VERDICT_CRC_BAD) begin
					tally[got.verdict]++;
				end
				if (got.fatal_mark) begin
					fatal_observed = 1'b1;
				end
				if (owed_q.size() == 0) begin
					errors++;
					if (errors <= 10) begin
						$display("unexpected item %0d: byte=%h tdata=%h", seen_total,
						         got.byte_val, m_axis_tdata);
					end
				end else begin
					want = owed_q.pop_front();
					if (got !== want) begin
						errors++;
						if (errors <= 10) begin
							$display("mismatch at item %0d", seen_total);
							$display("  exp byte=%h fr=%b st=%b end=%b v=%0d ",
							         want.byte_val, want.in_frame, want.start_mark,
							         want.end_mark, want.verdict,
							         "len=%0d lvl=%0d cnt=%0d fat=%b pad=%h",
							         want.length, want.level, want.bad_count,
							         want.fatal_mark, want.pad);
							$display("  got byte=%h fr=%b st=%b end=%b v=%0d ",
							         got.byte_val, got.in_frame, got.start_mark,
							         got.end_mark, got.verdict,
							         "len=%0d lvl=%0d cnt=%0d fat=%b pad=%h",
							         got.length, got.level, got.bad_count,
							         got.fatal_mark, got.pad);
						end
					end
				end
			end
			if (stall_left != 0) begin
				stall_left <= stall_left - 1;
				m_axis_tready <= 1'b0;
			end else if (!calm && $urandom_range(0, 11) == 0) begin
				stall_left <= $urandom_range(0, 18);
				m_axis_tready <= 1'b0;
			end else begin
				m_axis_tready <= 1'b1;
			end
		end
	end

	// Drop the run if it hangs
	always @(posedge clk) begin
		cycles++;
		if (cycles > RUN_LIMIT) begin
			$display("testbench: errors");
			$finish;
		end
	end

	// ------------------------------------------------------------- stimulus
	task automatic feed_byte(input logic [7:0] b);
		byte_q = {byte_q, b};
		queued_total++;
	endtask

	// Queue one frame; the CRC is correct unless spoiled
	task automatic queue_frame(input int unsigned len, input logic [5:0] resv,
	                           input bit zero_fill, input bit spoil_crc);
		logic [7:0]  h1;
		logic [7:0]  h2;
		logic [7:0]  pb;
		logic [23:0] c;
		logic [9:0]  l10;
		l10 = len[9:0];
		h1 = {resv, l10[9:8]};
		h2 = l10[7:0];
		c = crc_next(crc_next(crc_next(24'h000000, rfc_pkg::PREAMBLE), h1), h2);
		feed_byte(rfc_pkg::PREAMBLE);
		feed_byte(h1);
		feed_byte(h2);
		for (int i = 0; i < len; i++) begin
			pb = zero_fill ? 8'h00 : 8'($urandom_range(0, 255));
			c = crc_next(c, pb);
			feed_byte(pb);
		end
		if (spoil_crc) begin
			c = c ^ (24'h000001 << $urandom_range(0, 23));
		end
		feed_byte(c[23:16]);
		feed_byte(c[15:8]);
		feed_byte(c[7:0]);
	endtask

	// A random mix of good frames, frames with a spoiled CRC, all-zero and empty
	// frames, noise, and frames cut off before their CRC
	task automatic queue_traffic(input int unsigned n);
		int unsigned start_count;
		int unsigned pick;
		int unsigned len;
		logic [7:0]  b;
		start_count = queued_total;
		while (queued_total - start_count < n) begin
			pick = $urandom_range(0, 99);
			len = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 40) : $urandom_range(1, 6);
			if (pick < 40) begin
				queue_frame(len, 6'($urandom_range(0, 63)), 1'b0, 1'b0);
			end else if (pick < 65) begin
				queue_frame(len, 6'($urandom_range(0, 63)), 1'b0, 1'b1);
			end else if (pick < 75) begin
				queue_frame(len, 6'($urandom_range(0, 63)), 1'b1, 1'b0);
			end else if (pick < 85) begin
				queue_frame(0, 6'($urandom_range(0, 63)), 1'b0, 1'($urandom_range(0, 1)));
			end else if (pick < 90) begin
				// header promises a short payload, the stream stops early and
				// the following bytes get eaten as the rest of this frame
				feed_byte(rfc_pkg::PREAMBLE);
				feed_byte({6'($urandom_range(0, 63)), 2'b00});
				feed_byte(8'($urandom_range(0, 8)));
				repeat ($urandom_range(0, 4)) feed_byte(8'($urandom_range(0, 255)));
			end else begin
				repeat ($urandom_range(1, 4)) begin
					b = 8'($urandom_range(0, 255));
					if (b == rfc_pkg::PREAMBLE) begin
						b = b ^ 8'h01;
					end
					feed_byte(b);
				end
			end
		end
	endtask

	// Wait until every owed item has come out, then let the pipe settle
	task automatic wait_drained();
		do @(negedge clk);
		while (byte_q.size() != 0 || s_axis_tvalid || owed_q.size() != 0);
		repeat (4) @(negedge clk);
	endtask

	// Write a threshold register while the block is idle
	task automatic write_threshold(input logic idx, input logic [9:0] val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == rfc_pkg::REG_WARN_THRESHOLD) begin
			warn_thr = val;
		end else begin
			fatal_thr = val;
		end
		@(negedge clk);
	endtask

	initial begin
		// Directed part under reset thresholds: noise at both byte extremes,
		// an empty frame with all reserved bits set, an all-zero payload,
		// a good frame and a CRC mismatch
		feed_byte(8'h00);
		feed_byte(8'hFF);
		queue_frame(0, 6'h3F, 1'b0, 1'b0);
		queue_frame(1, 6'h00, 1'b1, 1'b0);
		queue_frame(2, 6'h15, 1'b0, 1'b0);
		queue_frame(1, 6'h2A, 1'b0, 1'b1);

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		// Mixed traffic under reset thresholds
		queue_traffic(80);
		wait_drained();

		// Lowest warn threshold: escalation on the first bad frame, errors after
		write_threshold(rfc_pkg::REG_WARN_THRESHOLD, 10'd1);
		write_threshold(rfc_pkg::REG_FATAL_THRESHOLD, 10'd1023);
		queue_traffic(60);
		wait_drained();

		// Highest thresholds: a long warning streak, then clear it
		write_threshold(rfc_pkg::REG_WARN_THRESHOLD, 10'd1023);
		repeat (10) queue_frame(0, 6'($urandom_range(0, 63)), 1'b0, 1'b0);
		queue_frame(1, 6'($urandom_range(0, 63)), 1'b1, 1'b0);
		queue_frame(3, 6'($urandom_range(0, 63)), 1'b0, 1'b0);
		queue_traffic(20);
		wait_drained();

		// Zero thresholds act as one
		write_threshold(rfc_pkg::REG_WARN_THRESHOLD, 10'd0);
		write_threshold(rfc_pkg::REG_FATAL_THRESHOLD, 10'd0);
		queue_traffic(50);
		wait_drained();

		// Warn above fatal, and no idling on either side from here on
		write_threshold(rfc_pkg::REG_WARN_THRESHOLD, 10'd6);
		write_threshold(rfc_pkg::REG_FATAL_THRESHOLD, 10'd2);
		calm = 1'b1;
		queue_traffic(50);
		// Close with a header that sets every length bit; the frame stays open
		feed_byte(rfc_pkg::PREAMBLE);
		feed_byte(8'hFF);
		feed_byte(8'hFF);
		repeat (5) feed_byte(8'($urandom_range(0, 255)));
		wait_drained();
		repeat (8) @(negedge clk);

		if (owed_q.size() != 0) begin
			errors++;
			$display("%0d items never came out", owed_q.size());
		end
		$display("run covered %0d bytes in, %0d items out over %0d cycles",
		         sent_total, seen_total, cycles);
		$display("frames good/empty/all-zero/crc-bad %0d/%0d/%0d/%0d, fatal flag seen %0d",
		         tally[rfc_pkg::VERDICT_GOOD], tally[rfc_pkg::VERDICT_EMPTY],
		         tally[rfc_pkg::VERDICT_ZERO], tally[rfc_pkg::VERDICT_CRC_BAD],
		         fatal_observed);
		if (errors == 0) begin
			$display("testbench: clean");
		end else begin
			$display("testbench: errors");
		end
		$finish;
	end

endmodule

`default_nettype wire

FILE: sim.f
rtl/rfc_pkg.sv
rtl/rfc_framer.sv
rtl/rfc_health.sv
rtl/rtcm3_frame_checker_unit.sv
tb/sv/testbench.sv
